>>> sv/lmdc_pkg.sv
// ----------------------------------------------------------------------------
// lmdc_pkg
// shared types and constants of the lock manager deadlock check block
// ----------------------------------------------------------------------------
package lmdc_pkg;

  localparam int unsigned MutexSlots = 16;
  localparam int unsigned EdgeSlots  = 16;
  localparam int unsigned TaskSlots  = 16;

  localparam int unsigned MutexW = $clog2(MutexSlots);
  localparam int unsigned EdgeW  = $clog2(EdgeSlots);
  localparam int unsigned TaskW  = $clog2(TaskSlots);
  localparam int unsigned CntW   = EdgeW + 1;

  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_CANCEL  = 2'd2,
    REQ_CHECK   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_WAITING  = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_BAD_IDX  = 3'd3,
    ST_RELEASED = 3'd4,
    ST_CHECKED  = 3'd5
  } status_e;

  localparam logic [1:0] RegMutexesInUse = 2'd0;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] task_id;
    logic [3:0] mutex_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        deadlock_found;
    logic        owner_valid;
    logic [3:0]  owner_task;
    logic [15:0] grant_total;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_req;
    logic find_start;
    logic find_step;
    logic add_edge;
    logic drop_last;
    logic remove_found;
    logic search_init;
    logic root_step;
    logic walk_step;
    logic grant;
    logic release_own;
    logic build_rsp;
    logic [2:0] rsp_status;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic idx_ok;
    logic req_kind_ok;
    logic [1:0] req_type;
    logic find_done;
    logic find_hit;
    logic edges_full;
    logic roots_done;
    logic walk_done;
    logic cycle;
    logic mutex_owned;
  } sts_t;

endpackage

>>> sv/lmdc_if.sv
// ----------------------------------------------------------------------------
// lmdc_req_if / lmdc_rsp_if
// valid/ready channels carrying request and response items
// ----------------------------------------------------------------------------
interface lmdc_req_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [3:0]           task_id;
  logic [3:0]           mutex_id;
  modport source (output valid, output req_type, output task_id, output mutex_id,
                  input ready);
  modport sink (input valid, input req_type, input task_id, input mutex_id,
                output ready);
endinterface

interface lmdc_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        deadlock_found;
  logic        owner_valid;
  logic [3:0]  owner_task;
  logic [15:0] grant_total;
  modport source (output valid, output status, output deadlock_found,
                  output owner_valid, output owner_task, output grant_total,
                  input ready);
  modport sink (input valid, input status, input deadlock_found,
                input owner_valid, input owner_task, input grant_total,
                output ready);
endinterface

>>> sv/lmdc_datapath.sv
// ----------------------------------------------------------------------------
// lmdc_datapath
// lock table, wait edge table and depth-first walk engine
// ----------------------------------------------------------------------------
module lmdc_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lmdc_pkg::req_t   req_i,
  input  logic [4:0]       slots_i,
  input  lmdc_pkg::cmd_t   cmd_i,
  output lmdc_pkg::sts_t   sts_o,
  output lmdc_pkg::rsp_t   rsp_o
);
  import lmdc_pkg::*;

  logic [TaskW-1:0]  owner_task_q [MutexSlots];
  logic [MutexSlots-1:0] owner_valid_q;
  logic [15:0]       grant_q [MutexSlots];
  logic [TaskW-1:0]  edge_task_q [EdgeSlots];
  logic [MutexW-1:0] edge_mutex_q [EdgeSlots];
  logic [CntW-1:0]   edge_cnt_q;

  req_t              req_q;
  logic [CntW-1:0]   scan_q;
  logic              hit_q;
  logic [EdgeW-1:0]  hit_idx_q;
  logic              added_q;

  logic [MutexSlots-1:0] visited_q, on_path_q;
  logic [MutexW-1:0] stk_m_q [MutexSlots];
  logic [CntW-1:0]   stk_e_q [MutexSlots];
  logic [MutexW:0]   top_q;
  logic [MutexW:0]   root_q;
  logic              cycle_q;
  logic              walk_done_q;
  rsp_t              rsp_q;

  logic [MutexW-1:0] tm;
  logic [CntW-1:0]   te;
  logic [EdgeW-1:0]  te_idx;
  logic [MutexW-1:0] nm;
  logic [CntW-1:0]   last;
  logic [MutexW-1:0] mx;

  assign mx     = req_q.mutex_id[MutexW-1:0];
  assign tm     = stk_m_q[top_q[MutexW-1:0] - MutexW'(1)];
  assign te     = stk_e_q[top_q[MutexW-1:0] - MutexW'(1)];
  assign te_idx = te[EdgeW-1:0];
  assign nm     = edge_mutex_q[te_idx];
  assign last   = edge_cnt_q - CntW'(1);

  always_comb begin
    sts_o.idx_ok      = ({1'b0, req_q.mutex_id} < slots_i) &&
                        ({1'b0, req_q.mutex_id} < 5'(MutexSlots));
    sts_o.req_kind_ok = 1'b1;
    sts_o.req_type    = req_q.req_type;
    sts_o.find_done   = hit_q || (scan_q >= edge_cnt_q);
    sts_o.find_hit    = hit_q;
    sts_o.edges_full  = edge_cnt_q >= CntW'(EdgeSlots);
    sts_o.roots_done  = cycle_q || (root_q >= (slots_i > 5'(MutexSlots) ?
                        (MutexW+1)'(MutexSlots) : (MutexW+1)'(slots_i)));
    sts_o.walk_done   = walk_done_q;
    sts_o.cycle       = cycle_q;
    sts_o.mutex_owned = owner_valid_q[mx];
  end

  assign rsp_o = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_valid_q <= '0;
      edge_cnt_q    <= '0;
      for (int i = 0; i < MutexSlots; i++) begin
        owner_task_q[i] <= '0;
        grant_q[i]      <= '0;
      end
      visited_q   <= '0;
      on_path_q   <= '0;
      top_q       <= '0;
      root_q      <= '0;
      cycle_q     <= 1'b0;
      walk_done_q <= 1'b1;
      hit_q       <= 1'b0;
      added_q     <= 1'b0;
      scan_q      <= '0;
    end else begin
      if (cmd_i.load_req) begin
        req_q <= req_i;
      end
      if (cmd_i.find_start) begin
        scan_q <= '0;
        hit_q  <= 1'b0;
      end
      if (cmd_i.find_step && !hit_q && scan_q < edge_cnt_q) begin
        if (edge_task_q[scan_q[EdgeW-1:0]] == req_q.task_id[TaskW-1:0] &&
            edge_mutex_q[scan_q[EdgeW-1:0]] == mx) begin
          hit_q     <= 1'b1;
          hit_idx_q <= scan_q[EdgeW-1:0];
        end else begin
          scan_q <= scan_q + CntW'(1);
        end
      end
      if (cmd_i.add_edge) begin
        added_q <= !sts_o.edges_full && !hit_q;
        if (!sts_o.edges_full && !hit_q) begin
          edge_task_q[edge_cnt_q[EdgeW-1:0]]  <= req_q.task_id[TaskW-1:0];
          edge_mutex_q[edge_cnt_q[EdgeW-1:0]] <= mx;
          edge_cnt_q <= edge_cnt_q + CntW'(1);
        end
      end
      if (cmd_i.drop_last && added_q) begin
        edge_cnt_q <= last;
      end
      if (cmd_i.remove_found && hit_q) begin
        edge_cnt_q <= last;
        edge_task_q[hit_idx_q]  <= edge_task_q[last[EdgeW-1:0]];
        edge_mutex_q[hit_idx_q] <= edge_mutex_q[last[EdgeW-1:0]];
      end
      if (cmd_i.search_init) begin
        visited_q   <= '0;
        on_path_q   <= '0;
        root_q      <= '0;
        cycle_q     <= 1'b0;
        walk_done_q <= 1'b1;
        top_q       <= '0;
      end
      if (cmd_i.root_step) begin
        if (!visited_q[root_q[MutexW-1:0]]) begin
          visited_q[root_q[MutexW-1:0]] <= 1'b1;
          on_path_q[root_q[MutexW-1:0]] <= 1'b1;
          stk_m_q[0]  <= root_q[MutexW-1:0];
          stk_e_q[0]  <= '0;
          top_q       <= (MutexW+1)'(1);
          walk_done_q <= 1'b0;
        end
        root_q <= root_q + (MutexW+1)'(1);
      end
      if (cmd_i.walk_step && !walk_done_q) begin
        if (!owner_valid_q[tm] || te >= edge_cnt_q) begin
          on_path_q[tm] <= 1'b0;
          top_q <= top_q - (MutexW+1)'(1);
          if (top_q == (MutexW+1)'(1)) walk_done_q <= 1'b1;
        end else begin
          stk_e_q[top_q[MutexW-1:0] - MutexW'(1)] <= te + CntW'(1);
          if (edge_task_q[te_idx] == owner_task_q[tm]) begin
            if (on_path_q[nm]) begin
              cycle_q     <= 1'b1;
              walk_done_q <= 1'b1;
            end else if (!visited_q[nm] && top_q < (MutexW+1)'(MutexSlots)) begin
              visited_q[nm] <= 1'b1;
              on_path_q[nm] <= 1'b1;
              stk_m_q[top_q[MutexW-1:0]] <= nm;
              stk_e_q[top_q[MutexW-1:0]] <= '0;
              top_q <= top_q + (MutexW+1)'(1);
            end
          end
        end
      end
      if (cmd_i.grant) begin
        owner_valid_q[mx] <= 1'b1;
        owner_task_q[mx]  <= req_q.task_id[TaskW-1:0];
        if (grant_q[mx] != 16'hFFFF) grant_q[mx] <= grant_q[mx] + 16'd1;
      end
      if (cmd_i.release_own) begin
        owner_valid_q[mx] <= 1'b0;
        owner_task_q[mx]  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.build_rsp) begin
      rsp_q.status <= cmd_i.rsp_status;
      if (cmd_i.rsp_status == ST_BAD_IDX) begin
        rsp_q.deadlock_found <= 1'b0;
        rsp_q.owner_valid    <= 1'b0;
        rsp_q.owner_task     <= '0;
        rsp_q.grant_total    <= '0;
      end else begin
        rsp_q.deadlock_found <= cycle_q && (cmd_i.rsp_status == ST_REFUSED ||
                                            cmd_i.rsp_status == ST_CHECKED);
        rsp_q.owner_valid    <= sts_o.idx_ok && owner_valid_q[mx];
        rsp_q.owner_task     <= (sts_o.idx_ok && owner_valid_q[mx]) ?
                                4'(owner_task_q[mx]) : 4'd0;
        rsp_q.grant_total    <= sts_o.idx_ok ? grant_q[mx] : 16'd0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_cnt_q <= CntW'(EdgeSlots))
    else $error("edge count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= (MutexW+1)'(MutexSlots))
    else $error("walk stack overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (on_path_q & ~visited_q) == '0)
    else $error("on-path mutex not visited");
endmodule

>>> sv/lmdc_ctrl.sv
// ----------------------------------------------------------------------------
// lmdc_ctrl
// request sequencer: edge lookup, cycle search and table update
// ----------------------------------------------------------------------------
module lmdc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  lmdc_pkg::sts_t sts_i,
  output lmdc_pkg::cmd_t cmd_o
);
  import lmdc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_FIND, S_ADD, S_ROOT, S_WALK, S_DECIDE,
    S_RFIND, S_REMOVE, S_RESP, S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic [2:0] status_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.rsp_status = status_q;
    cmd_o.load_req = in_valid_i && in_ready_o;
    case (state_q)
      S_DECODE: cmd_o.find_start = 1'b1;
      S_FIND:   cmd_o.find_step = 1'b1;
      S_ADD:    begin
        cmd_o.add_edge = (sts_i.req_type == REQ_ACQUIRE);
        cmd_o.search_init = 1'b1;
      end
      S_ROOT:   if (!sts_i.roots_done) cmd_o.root_step = 1'b1;
      S_WALK:   cmd_o.walk_step = 1'b1;
      S_DECIDE: begin
        if (sts_i.req_type == REQ_ACQUIRE) begin
          if (sts_i.cycle) cmd_o.drop_last = 1'b1;
          else if (!sts_i.mutex_owned) begin
            cmd_o.grant = 1'b1;
            cmd_o.find_start = 1'b1;
          end
        end
      end
      S_RFIND:  cmd_o.find_step = 1'b1;
      S_REMOVE: begin
        if (sts_i.req_type == REQ_RELEASE) cmd_o.release_own = 1'b1;
        else cmd_o.remove_found = 1'b1;
      end
      S_RESP:   cmd_o.build_rsp = !out_valid_q;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      status_q    <= ST_CHECKED;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE:   if (in_valid_i && in_ready_o) state_q <= S_DECODE;
        S_DECODE: begin
          if (sts_i.req_type != REQ_CHECK && !sts_i.idx_ok) begin
            status_q <= ST_BAD_IDX;
            state_q  <= S_RESP;
          end else begin
            case (sts_i.req_type)
              REQ_ACQUIRE: state_q <= S_FIND;
              REQ_RELEASE: begin
                status_q <= ST_RELEASED;
                state_q  <= S_REMOVE;
              end
              REQ_CANCEL: begin
                status_q <= ST_RELEASED;
                state_q  <= S_RFIND;
              end
              default: begin
                status_q <= ST_CHECKED;
                state_q  <= S_ADD;
              end
            endcase
          end
        end
        S_FIND:   if (sts_i.find_done) state_q <= S_ADD;
        S_ADD:    state_q <= S_ROOT;
        S_ROOT:   state_q <= sts_i.roots_done ? S_DECIDE : S_WALK;
        S_WALK:   if (sts_i.walk_done) state_q <= S_ROOT;
        S_DECIDE: begin
          if (sts_i.req_type == REQ_ACQUIRE) begin
            if (sts_i.cycle) begin
              status_q <= ST_REFUSED;
              state_q  <= S_RESP;
            end else if (!sts_i.mutex_owned) begin
              status_q <= ST_GRANTED;
              state_q  <= S_RFIND;
            end else begin
              status_q <= ST_WAITING;
              state_q  <= S_RESP;
            end
          end else begin
            state_q <= S_RESP;
          end
        end
        S_RFIND:  if (sts_i.find_done) state_q <= S_REMOVE;
        S_REMOVE: state_q <= S_RESP;
        S_RESP:   if (!out_valid_q) state_q <= S_OUT;
        S_OUT: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> !out_valid_q)
    else $error("result overwritten while pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> out_valid_q)
    else $error("result not raised");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("result dropped");
endmodule

>>> sv/lock_manager_deadlock_check_core.sv
// ----------------------------------------------------------------------------
// lock_manager_deadlock_check_core
// lock table with wait-for-graph deadlock refusal
// ----------------------------------------------------------------------------
// One request at a time. Acquire and check run a depth-first search stepping
// one edge per cycle (up to one step per edge per stacked mutex, plus a root
// step per root), and edge lookups scan the edge table one entry per cycle. A
// new request may be taken while the previous result still waits; it holds
// before its own result until that one is taken.
module lock_manager_deadlock_check_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  lmdc_req_if.sink    req_if,
  lmdc_rsp_if.source  rsp_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lmdc_pkg::*;

  logic [4:0] slots_q;
  req_t req;
  rsp_t rsp;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2:1] == RegMutexesInUse) ? {27'd0, slots_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= '0;
    end else if (psel && penable && pwrite && paddr[2:1] == RegMutexesInUse) begin
      slots_q <= pwdata[4:0];
    end
  end

  assign req.req_type = req_if.req_type;
  assign req.task_id  = req_if.task_id;
  assign req.mutex_id = req_if.mutex_id;

  lmdc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req_if.valid),
    .in_ready_o (req_if.ready),
    .out_valid_o(rsp_if.valid),
    .out_ready_i(rsp_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lmdc_datapath u_dp (
    .clk_i, .rst_ni,
    .req_i  (req),
    .slots_i(slots_q),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp)
  );

  assign rsp_if.status         = rsp.status;
  assign rsp_if.deadlock_found = rsp.deadlock_found;
  assign rsp_if.owner_valid    = rsp.owner_valid;
  assign rsp_if.owner_task     = rsp.owner_task;
  assign rsp_if.grant_total    = rsp.grant_total;
endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lock manager deadlock check core. A behavioral
// lock table with its own wait-for-graph cycle search predicts every response.
// Directed tests cover grants, self and two-task deadlocks, bad indexes and a
// full edge table. Random phases then run under several mutex counts, with
// random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_top;
  import lmdc_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lmdc_req_if req_if ();
  lmdc_rsp_if rsp_if ();

  lock_manager_deadlock_check_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_if  (req_if.sink),
    .rsp_if  (rsp_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // lock table mirror
  logic [4:0]  lt_in_use;
  logic [3:0]  lt_owner   [MutexSlots];
  logic        lt_owned   [MutexSlots];
  logic [15:0] lt_grants  [MutexSlots];
  logic [3:0]  lt_e_task  [EdgeSlots];
  logic [3:0]  lt_e_mutex [EdgeSlots];
  int          lt_edges;
  bit          lt_seen    [MutexSlots];
  bit          lt_on_path [MutexSlots];

  rsp_t rsp_expected[$];
  int   mismatches;
  bit   no_idle;

  function automatic int slots_used();
    return (lt_in_use > MutexSlots) ? MutexSlots : int'(lt_in_use);
  endfunction

  function automatic bit walk_has_cycle(int start);
    int stk [MutexSlots];
    int pos [MutexSlots];
    int top;
    int m;
    int e;
    int n;
    top = 1;
    stk[0] = start;
    pos[0] = 0;
    lt_seen[start] = 1;
    lt_on_path[start] = 1;
    while (top > 0) begin
      m = stk[top-1];
      e = pos[top-1];
      if (!lt_owned[m] || e >= lt_edges) begin
        lt_on_path[m] = 0;
        top--;
        continue;
      end
      pos[top-1] = e + 1;
      if (lt_e_task[e] == lt_owner[m]) begin
        n = lt_e_mutex[e];
        if (lt_on_path[n]) return 1;
        if (!lt_seen[n] && top < MutexSlots) begin
          lt_seen[n] = 1;
          lt_on_path[n] = 1;
          stk[top] = n;
          pos[top] = 0;
          top++;
        end
      end
    end
    return 0;
  endfunction

  function automatic bit graph_has_cycle();
    for (int i = 0; i < MutexSlots; i++) begin
      lt_seen[i] = 0;
      lt_on_path[i] = 0;
    end
    for (int i = 0; i < slots_used(); i++)
      if (!lt_seen[i] && walk_has_cycle(i)) return 1;
    return 0;
  endfunction

  function automatic int edge_index(logic [3:0] t, logic [3:0] m);
    for (int i = 0; i < lt_edges; i++)
      if (lt_e_task[i] == t && lt_e_mutex[i] == m) return i;
    return -1;
  endfunction

  function automatic void drop_edge(logic [3:0] t, logic [3:0] m);
    int i;
    i = edge_index(t, m);
    if (i >= 0) begin
      lt_edges--;
      lt_e_task[i] = lt_e_task[lt_edges];
      lt_e_mutex[i] = lt_e_mutex[lt_edges];
    end
  endfunction

  function automatic rsp_t predict_lock_rsp(req_e rt, logic [3:0] t, logic [3:0] m);
    rsp_t r;
    bit   ok;
    bit   added;
    bit   found;
    status_e st;
    ok = (m < slots_used());
    found = 0;
    st = ST_CHECKED;
    r = '0;
    if (rt != REQ_CHECK && !ok) begin
      r.status = ST_BAD_IDX;
      return r;
    end
    case (rt)
      REQ_ACQUIRE: begin
        added = 0;
        if (lt_edges < EdgeSlots && edge_index(t, m) < 0) begin
          lt_e_task[lt_edges] = t;
          lt_e_mutex[lt_edges] = m;
          lt_edges++;
          added = 1;
        end
        found = graph_has_cycle();
        if (found) begin
          if (added) lt_edges--;
          st = ST_REFUSED;
        end else if (!lt_owned[m]) begin
          lt_owned[m] = 1;
          lt_owner[m] = t;
          drop_edge(t, m);
          if (lt_grants[m] != 16'hffff) lt_grants[m]++;
          st = ST_GRANTED;
        end else begin
          st = ST_WAITING;
        end
      end
      REQ_RELEASE: begin
        lt_owned[m] = 0;
        lt_owner[m] = '0;
        st = ST_RELEASED;
      end
      REQ_CANCEL: begin
        drop_edge(t, m);
        st = ST_RELEASED;
      end
      default: begin
        found = graph_has_cycle();
        st = ST_CHECKED;
      end
    endcase
    r.status = st;
    r.deadlock_found = found;
    if (ok && lt_owned[m]) begin
      r.owner_valid = 1;
      r.owner_task = lt_owner[m];
    end
    r.grant_total = ok ? lt_grants[m] : 16'd0;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // response stalls
  initial begin
    rsp_if.ready = 0;
    @(posedge rst_ni);
    forever begin
      int g;
      g = pick_gap();
      if (g > 0) begin
        rsp_if.ready <= 0;
        repeat (g) @(posedge clk_i);
      end
      rsp_if.ready <= 1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      rsp_t exp;
      if (rsp_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response item");
      end else begin
        exp = rsp_expected.pop_front();
        if (rsp_if.status !== exp.status || rsp_if.deadlock_found !== exp.deadlock_found ||
            rsp_if.owner_valid !== exp.owner_valid || rsp_if.owner_task !== exp.owner_task ||
            rsp_if.grant_total !== exp.grant_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d dl=%0d ov=%0d ot=%0d gt=%0d got st=%0d dl=%0d ov=%0d ot=%0d gt=%0d",
                     exp.status, exp.deadlock_found, exp.owner_valid, exp.owner_task,
                     exp.grant_total, rsp_if.status, rsp_if.deadlock_found,
                     rsp_if.owner_valid, rsp_if.owner_task, rsp_if.grant_total);
        end
      end
    end
  end

  task automatic send_lock_req(req_e rt, logic [3:0] t, logic [3:0] m);
    int g;
    g = pick_gap();
    if (g > 0) begin
      req_if.valid <= 0;
      repeat (g) @(posedge clk_i);
    end
    req_if.valid <= 1;
    req_if.req_type <= rt;
    req_if.task_id <= t;
    req_if.mutex_id <= m;
    do @(posedge clk_i); while (!req_if.ready);
    rsp_expected.push_back(predict_lock_rsp(rt, t, m));
  endtask

  task automatic write_in_use(logic [4:0] v);
    req_if.valid <= 0;
    wait (rsp_expected.size() == 0);
    repeat (5) @(posedge clk_i);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= 3'({RegMutexesInUse, 2'b00});
    pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    lt_in_use = v;
  endtask

  task automatic test_grant_and_deadlock();
    write_in_use(5'd16);
    send_lock_req(REQ_ACQUIRE, 4'd0, 4'd0);
    send_lock_req(REQ_ACQUIRE, 4'd0, 4'd0);
    send_lock_req(REQ_ACQUIRE, 4'd15, 4'd15);
    send_lock_req(REQ_ACQUIRE, 4'd0, 4'd15);
    send_lock_req(REQ_ACQUIRE, 4'd0, 4'd15);
    send_lock_req(REQ_ACQUIRE, 4'd15, 4'd0);
    send_lock_req(REQ_CHECK, 4'd3, 4'd0);
    send_lock_req(REQ_RELEASE, 4'd7, 4'd15);
    send_lock_req(REQ_CANCEL, 4'd0, 4'd15);
    send_lock_req(REQ_RELEASE, 4'd0, 4'd0);
  endtask

  task automatic test_bad_index();
    write_in_use(5'd4);
    send_lock_req(REQ_ACQUIRE, 4'd1, 4'd4);
    send_lock_req(REQ_RELEASE, 4'd1, 4'd15);
    send_lock_req(REQ_CANCEL, 4'd1, 4'd9);
    send_lock_req(REQ_CHECK, 4'd1, 4'd12);
    write_in_use(5'd31);
    send_lock_req(REQ_ACQUIRE, 4'd2, 4'd15);
  endtask

  task automatic test_edge_table_full();
    write_in_use(5'd16);
    send_lock_req(REQ_ACQUIRE, 4'd0, 4'd1);
    for (int t = 1; t < 16; t++) send_lock_req(REQ_ACQUIRE, 4'(t), 4'd1);
    send_lock_req(REQ_ACQUIRE, 4'd1, 4'd2);
    send_lock_req(REQ_ACQUIRE, 4'd3, 4'd2);
    send_lock_req(REQ_ACQUIRE, 4'd4, 4'd2);
    send_lock_req(REQ_ACQUIRE, 4'd2, 4'd2);
    send_lock_req(REQ_ACQUIRE, 4'd1, 4'd1);
  endtask

  task automatic test_random_phase(logic [4:0] cfg, int items);
    int p;
    int lim;
    int mm;
    req_e rt;
    logic [3:0] t;
    logic [3:0] m;
    write_in_use(cfg);
    no_idle = ($urandom_range(3) == 0);
    lim = (slots_used() > 0) ? slots_used() - 1 : 0;
    for (int i = 0; i < items; i++) begin
      p = $urandom_range(99);
      if (p < 50) rt = REQ_ACQUIRE;
      else if (p < 70) rt = REQ_RELEASE;
      else if (p < 85) rt = REQ_CANCEL;
      else rt = REQ_CHECK;
      t = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(5));
      m = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(lim));
      if (rt == REQ_RELEASE && lt_owned[m] && $urandom_range(3) != 0) t = lt_owner[m];
      if (rt == REQ_CANCEL && lt_edges > 0 && $urandom_range(3) != 0) begin
        mm = $urandom_range(lt_edges - 1);
        t = lt_e_task[mm];
        m = lt_e_mutex[mm];
      end
      send_lock_req(rt, t, m);
    end
  endtask

  initial begin
    #16000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    mismatches = 0;
    no_idle = 0;
    rst_ni = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 0;
    req_if.req_type = REQ_ACQUIRE;
    req_if.task_id = '0;
    req_if.mutex_id = '0;
    lt_in_use = '0;
    lt_edges = 0;
    for (int i = 0; i < MutexSlots; i++) begin
      lt_owner[i] = '0;
      lt_owned[i] = 0;
      lt_grants[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    test_grant_and_deadlock();
    test_bad_index();
    test_edge_table_full();
    test_random_phase(5'd16, 300);
    test_random_phase(5'd31, 200);
    test_random_phase(5'd3, 200);
    test_random_phase(5'd1, 100);
    test_random_phase(5'd0, 60);
    test_random_phase(5'd9, 200);
    test_random_phase(5'd16, 240);
    req_if.valid <= 0;
    wait (rsp_expected.size() == 0);
    repeat (400) @(posedge clk_i);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
